FILE: hdl/bfes_pkg.sv
// Shared types and constants for the binned feature eviction scorer.
`default_nettype none

package bfes_pkg;

	localparam int unsigned CMD_W          = 3;
	localparam int unsigned ADDR_W         = 7;
	localparam int unsigned DATA_W         = 64;
	localparam int unsigned COUNT_W        = 4;
	localparam int unsigned INPUT_FEATURES = 9;

	localparam logic [DATA_W-1:0] SCORE_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] SCORE_EVICT_FIRST = 64'hC000_0000_0000_0000;
	localparam logic [COUNT_W-1:0] COUNT_SAT        = 4'hF;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_EDGE   = 3'd0,
		CMD_LOAD_WEIGHT = 3'd1,
		CMD_LOAD_COUNT  = 3'd2,
		CMD_SCORE       = 3'd3,
		CMD_UNTRACKED   = 3'd4,
		CMD_NO_EVICT    = 3'd5
	} cmd_t;

	// what the output stage does with an item
	typedef enum logic [1:0] {
		KIND_SCORE       = 2'd0,
		KIND_EVICT_FIRST = 2'd1,
		KIND_MAX         = 2'd2
	} kind_t;

	typedef logic [DATA_W-1:0] word_t;

	// table write broadcast to every lane
	typedef struct packed {
		logic              edge_we;
		logic              weight_we;
		logic              count_we;
		logic [ADDR_W-1:0] addr;
		word_t             value;
	} lane_wr_t;

endpackage

`default_nettype wire

FILE: hdl/binned_feature_eviction_scorer_top.sv
// Top level of the binned feature eviction scorer.
// Takes one item per clock when the output side keeps up. Load commands write the edge,
// weight or bin count tables at the edge that accepts them and give no result; a later
// item always sees them. Score, untracked and not-evictable items each give one score:
// the FEATURE_COUNT lanes look up their bins at acceptance, where the weights are
// registered, then one registered adder level per tree stage, then the
// output register. The input stalls only while a result waits at a stalled output and
// every stage behind it is full. Tables reset to unwritten except the bin counts,
// which clear so that every feature starts disabled.
`default_nettype none

module binned_feature_eviction_scorer_top #(
	parameter int unsigned FEATURE_COUNT = 9,
	parameter int unsigned BIN_LIMIT     = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [2:0]  command,
	input  wire logic [6:0]  table_addr,
	input  wire logic [63:0] load_value,
	input  wire logic [63:0] page_delta,
	input  wire logic [63:0] file_bytes,
	input  wire logic [31:0] page_hotness,
	input  wire logic [31:0] seq_distance,
	input  wire logic [63:0] page_delta_prev,
	input  wire logic [63:0] file_delta,
	input  wire logic [63:0] file_delta_prev,
	input  wire logic [31:0] file_hotness,
	input  wire logic [63:0] idle_time,
	output logic             score_valid,
	input  wire logic        score_stall,
	output logic signed [63:0] score
);

	logic               accept;
	logic               ready;
	logic               take;
	bfes_pkg::kind_t    kind;
	bfes_pkg::lane_wr_t wr;
	bfes_pkg::word_t    feat_in     [bfes_pkg::INPUT_FEATURES];
	bfes_pkg::word_t    lane_feat   [FEATURE_COUNT];
	bfes_pkg::word_t    lane_weight [FEATURE_COUNT];

	assign stall  = !ready;
	assign accept = valid && ready;

	assign feat_in[0] = page_delta;
	assign feat_in[1] = file_bytes;
	assign feat_in[2] = {32'd0, page_hotness};
	assign feat_in[3] = {32'd0, seq_distance};
	assign feat_in[4] = page_delta_prev;
	assign feat_in[5] = file_delta;
	assign feat_in[6] = file_delta_prev;
	assign feat_in[7] = {32'd0, file_hotness};
	assign feat_in[8] = idle_time;

	always_comb begin
		wr        = '0;
		wr.addr   = table_addr;
		wr.value  = load_value;
		take      = 1'b0;
		kind      = bfes_pkg::KIND_SCORE;
		case (command)
			bfes_pkg::CMD_LOAD_EDGE: begin
				wr.edge_we = accept;
			end
			bfes_pkg::CMD_LOAD_WEIGHT: begin
				wr.weight_we = accept;
			end
			bfes_pkg::CMD_LOAD_COUNT: begin
				wr.count_we = accept;
			end
			bfes_pkg::CMD_SCORE: begin
				take = accept;
			end
			bfes_pkg::CMD_UNTRACKED: begin
				take = accept;
				kind = bfes_pkg::KIND_EVICT_FIRST;
			end
			bfes_pkg::CMD_NO_EVICT: begin
				take = accept;
				kind = bfes_pkg::KIND_MAX;
			end
			default: begin
				// unused codes are dropped
			end
		endcase
	end

	for (genvar g = 0; g < FEATURE_COUNT; g++) begin : g_lane
		if (g < bfes_pkg::INPUT_FEATURES) begin : g_fed
			assign lane_feat[g] = feat_in[g];
		end else begin : g_zero
			assign lane_feat[g] = '0;
		end

		bfes_lane #(
			.BIN_LIMIT (BIN_LIMIT),
			.LANE_IDX  (g)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.feature (lane_feat[g]),
			.weight  (lane_weight[g])
		);
	end

	bfes_merge #(
		.LANES (FEATURE_COUNT)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.kind        (kind),
		.weights     (lane_weight),
		.ready       (ready),
		.score_valid (score_valid),
		.score_stall (score_stall),
		.score       (score)
	);

endmodule

`default_nettype wire

FILE: hdl/bfes_lane.sv
// One feature lane: bin count, edges and weights of a feature, and the bin lookup.
`default_nettype none

module bfes_lane #(
	parameter int unsigned BIN_LIMIT = 10,
	parameter int unsigned LANE_IDX  = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bfes_pkg::lane_wr_t wr,
	input  wire bfes_pkg::word_t   feature,
	output bfes_pkg::word_t        weight
);

	localparam int unsigned BIN_W  = $clog2(BIN_LIMIT);
	localparam int unsigned EXT_W  = 9;
	localparam logic [EXT_W-1:0] ADDR_LO  = EXT_W'(LANE_IDX * BIN_LIMIT);
	localparam logic [EXT_W-1:0] ADDR_HI  = EXT_W'((LANE_IDX + 1) * BIN_LIMIT);
	localparam logic [EXT_W-1:0] COUNT_AD = EXT_W'(LANE_IDX);
	localparam logic [bfes_pkg::COUNT_W:0] LIMIT_EXT = (bfes_pkg::COUNT_W + 1)'(BIN_LIMIT);

	bfes_pkg::word_t                edge_q   [BIN_LIMIT];
	bfes_pkg::word_t                weight_q [BIN_LIMIT];
	logic [bfes_pkg::COUNT_W-1:0]   count_q;

	logic [EXT_W-1:0] addr_ext;
	logic [EXT_W-1:0] addr_off;
	logic             in_range;
	logic [BIN_W-1:0] wr_bin;
	logic [BIN_W-1:0] bin;
	logic             enabled;

	assign addr_ext = {{(EXT_W - bfes_pkg::ADDR_W){1'b0}}, wr.addr};
	assign addr_off = addr_ext - ADDR_LO;
	assign in_range = (addr_ext >= ADDR_LO) && (addr_ext < ADDR_HI);
	assign wr_bin   = addr_off[BIN_W-1:0];

	always_ff @(posedge clk) begin
		if (wr.edge_we && in_range) begin
			edge_q[wr_bin] <= wr.value;
		end
		if (wr.weight_we && in_range) begin
			weight_q[wr_bin] <= wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr.count_we && (addr_ext == COUNT_AD)) begin
			count_q <= (|wr.value[bfes_pkg::DATA_W-1:bfes_pkg::COUNT_W]) ?
				bfes_pkg::COUNT_SAT : wr.value[bfes_pkg::COUNT_W-1:0];
		end
	end

	// first interior edge above the feature wins, else the last bin
	always_comb begin
		bin     = BIN_W'(count_q - 4'd1);
		enabled = (count_q != '0) && ({1'b0, count_q} <= LIMIT_EXT);
		for (int b = BIN_LIMIT - 2; b >= 0; b--) begin
			if (((b + 1) < int'(count_q)) && (feature < edge_q[b])) begin
				bin = BIN_W'(b);
			end
		end
		weight = enabled ? weight_q[bin] : '0;
	end

endmodule

`default_nettype wire

FILE: hdl/bfes_merge.sv
// Registered adder tree over the lane weights, and the output register.
`default_nettype none

module bfes_merge #(
	parameter int unsigned LANES = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire bfes_pkg::kind_t   kind,
	input  wire bfes_pkg::word_t   weights [LANES],
	output logic                   ready,
	output logic                   score_valid,
	input  wire logic              score_stall,
	output logic signed [bfes_pkg::DATA_W-1:0] score
);

	localparam int unsigned LEVELS = $clog2(LANES);
	localparam int unsigned PAD    = 1 << LEVELS;

	bfes_pkg::word_t sum_q  [LEVELS+1][PAD];
	bfes_pkg::kind_t kind_q [LEVELS+1];
	logic [LEVELS:0] v_q;
	logic [LEVELS:0] adv;
	logic            out_en;
	logic            out_v_q;
	bfes_pkg::word_t score_q;

	// a level moves when it is empty or the level after it moves
	always_comb begin
		out_en      = !out_v_q || !score_stall;
		adv[LEVELS] = !v_q[LEVELS] || out_en;
		for (int lv = int'(LEVELS) - 1; lv >= 0; lv--) begin
			adv[lv] = !v_q[lv] || adv[lv + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= take;
			end
			for (int lv = 1; lv <= int'(LEVELS); lv++) begin
				if (adv[lv]) begin
					v_q[lv] <= v_q[lv - 1];
				end
			end
			if (out_en) begin
				out_v_q <= v_q[LEVELS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			kind_q[0] <= kind;
			for (int n = 0; n < int'(LANES); n++) begin
				sum_q[0][n] <= weights[n];
			end
			for (int n = LANES; n < int'(PAD); n++) begin
				sum_q[0][n] <= '0;
			end
		end
		for (int lv = 1; lv <= int'(LEVELS); lv++) begin
			if (adv[lv]) begin
				kind_q[lv] <= kind_q[lv - 1];
				for (int n = 0; n < int'(PAD >> lv); n++) begin
					sum_q[lv][n] <= sum_q[lv - 1][2 * n] + sum_q[lv - 1][2 * n + 1];
				end
			end
		end
		if (out_en) begin
			case (kind_q[LEVELS])
				bfes_pkg::KIND_EVICT_FIRST: begin
					score_q <= bfes_pkg::SCORE_EVICT_FIRST;
				end
				bfes_pkg::KIND_MAX: begin
					score_q <= bfes_pkg::SCORE_MAX;
				end
				bfes_pkg::KIND_SCORE: begin
					// the signed maximum is reserved for pages that must stay
					score_q <= (sum_q[LEVELS][0] == bfes_pkg::SCORE_MAX) ?
						bfes_pkg::SCORE_EVICT_FIRST : sum_q[LEVELS][0];
				end
				default: begin
					score_q <= bfes_pkg::SCORE_EVICT_FIRST;
				end
			endcase
		end
	end

	assign ready       = adv[0];
	assign score_valid = out_v_q;
	assign score       = score_q;

endmodule

`default_nettype wire

FILE: hdl/bfes_checker.sv
// Port-level checks for the scorer top level, bound to it.
`default_nettype none

module bfes_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        stall,
	input wire logic        score_valid,
	input wire logic        score_stall,
	input wire logic [63:0] score
);

	// no result can be pending while reset is applied
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !score_valid)
		else $error("score_valid high during reset");

	// the input only backs up behind a stalled, occupied output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!score_valid || !score_stall) |-> !stall)
		else $error("input stalled while output can drain");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid && score_stall) |=> score_valid)
		else $error("score item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid && score_stall) |=> $stable(score))
		else $error("score changed while stalled");

endmodule

bind binned_feature_eviction_scorer_top bfes_checker u_bfes_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.stall       (stall),
	.score_valid (score_valid),
	.score_stall (score_stall),
	.score       (score)
);

`default_nettype wire

FILE: bench/bfes_score_checker.sv
// Checker for the eviction scorer: mirrors the tables, predicts each score and compares.
`timescale 1ns / 1ps

module bfes_score_checker #(
	parameter int unsigned FEATURE_COUNT = 9,
	parameter int unsigned BIN_LIMIT     = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid,
	input  wire logic                          stall,
	input  wire logic [bfes_pkg::CMD_W-1:0]    command,
	input  wire logic [bfes_pkg::ADDR_W-1:0]   table_addr,
	input  wire logic [63:0]                   load_value,
	input  wire logic [63:0]                   page_delta,
	input  wire logic [63:0]                   file_bytes,
	input  wire logic [31:0]                   page_hotness,
	input  wire logic [31:0]                   seq_distance,
	input  wire logic [63:0]                   page_delta_prev,
	input  wire logic [63:0]                   file_delta,
	input  wire logic [63:0]                   file_delta_prev,
	input  wire logic [31:0]                   file_hotness,
	input  wire logic [63:0]                   idle_time,
	input  wire logic                          score_valid,
	input  wire logic                          score_stall,
	input  wire logic signed [63:0]            score,
	output int                                 fail_count,
	output int                                 pending
);

	localparam int unsigned TABLE_DEPTH = FEATURE_COUNT * BIN_LIMIT;

	logic [bfes_pkg::COUNT_W-1:0] bin_counts [FEATURE_COUNT];
	bfes_pkg::word_t              edge_mirror[TABLE_DEPTH];
	bfes_pkg::word_t              bin_weights[TABLE_DEPTH];
	bfes_pkg::word_t              score_queue[$];
	int                           shown;

	function automatic bfes_pkg::word_t bin_weight(int unsigned f, bfes_pkg::word_t x);
		int unsigned n;
		int unsigned b;
		n = 32'(bin_counts[f]);
		if (n == 0 || n > BIN_LIMIT)
			return '0;
		for (b = 0; b + 1 < n; b++) begin
			if (x < edge_mirror[f * BIN_LIMIT + b])
				break;
		end
		return bin_weights[f * BIN_LIMIT + b];
	endfunction

	function automatic bfes_pkg::word_t page_score();
		bfes_pkg::word_t feat [bfes_pkg::INPUT_FEATURES];
		bfes_pkg::word_t sum;
		bfes_pkg::word_t x;
		feat[0] = page_delta;
		feat[1] = file_bytes;
		feat[2] = {32'd0, page_hotness};
		feat[3] = {32'd0, seq_distance};
		feat[4] = page_delta_prev;
		feat[5] = file_delta;
		feat[6] = file_delta_prev;
		feat[7] = {32'd0, file_hotness};
		feat[8] = idle_time;
		sum = '0;
		for (int unsigned f = 0; f < FEATURE_COUNT; f++) begin
			x = (f < bfes_pkg::INPUT_FEATURES) ? feat[f] : '0;
			sum = sum + bin_weight(f, x);
		end
		// a sum landing on the signed max would read as not evictable
		return (sum == bfes_pkg::SCORE_MAX) ? bfes_pkg::SCORE_EVICT_FIRST : sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FEATURE_COUNT; i++)
				bin_counts[i] = '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				edge_mirror[i] = '0;
				bin_weights[i] = '0;
			end
			score_queue.delete();
			pending    = 0;
			fail_count = 0;
			shown      = 0;
		end else begin
			// results first: a score never leaves in the cycle its item enters
			if (score_valid && !score_stall) begin
				if (score_queue.size() == 0) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("unexpected score %h, nothing pending", score);
					end
				end else begin
					bfes_pkg::word_t want;
					want = score_queue.pop_front();
					if (score !== want) begin
						fail_count++;
						if (shown < 10) begin
							shown++;
							$display("score mismatch: expected %h, actual %h", want, score);
						end
					end
				end
			end
			if (valid && !stall) begin
				case (command)
					bfes_pkg::CMD_LOAD_EDGE: begin
						if (table_addr < TABLE_DEPTH)
							edge_mirror[table_addr] = load_value;
					end
					bfes_pkg::CMD_LOAD_WEIGHT: begin
						if (table_addr < TABLE_DEPTH)
							bin_weights[table_addr] = load_value;
					end
					bfes_pkg::CMD_LOAD_COUNT: begin
						if (table_addr < FEATURE_COUNT)
							bin_counts[table_addr] = (load_value > 64'd15) ?
								bfes_pkg::COUNT_SAT : load_value[bfes_pkg::COUNT_W-1:0];
					end
					bfes_pkg::CMD_SCORE:     score_queue.push_back(page_score());
					bfes_pkg::CMD_UNTRACKED: score_queue.push_back(bfes_pkg::SCORE_EVICT_FIRST);
					bfes_pkg::CMD_NO_EVICT:  score_queue.push_back(bfes_pkg::SCORE_MAX);
					default: ;
				endcase
			end
			pending = score_queue.size();
		end
	end

endmodule

FILE: bench/tb.sv
// Testbench top for the eviction scorer: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned FEATURE_COUNT  = 9;
	localparam int unsigned BIN_LIMIT      = 10;
	localparam int unsigned TABLE_DEPTH    = FEATURE_COUNT * BIN_LIMIT;
	localparam int unsigned ITEM_TARGET    = 1700;
	localparam int unsigned HOLD_AT        = 600;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned CALM_TAIL      = 150;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES   = 20;

	typedef logic [bfes_pkg::CMD_W-1:0]  code_t;
	typedef logic [bfes_pkg::ADDR_W-1:0] addr_t;
	typedef logic [bfes_pkg::INPUT_FEATURES-1:0][63:0] feat_vec_t;

	localparam code_t CMD_SPARE_LO = 3'd6;
	localparam code_t CMD_SPARE_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               valid;
	logic               stall;
	code_t              command;
	addr_t              table_addr;
	logic [63:0]        load_value;
	logic [63:0]        page_delta;
	logic [63:0]        file_bytes;
	logic [31:0]        page_hotness;
	logic [31:0]        seq_distance;
	logic [63:0]        page_delta_prev;
	logic [63:0]        file_delta;
	logic [63:0]        file_delta_prev;
	logic [31:0]        file_hotness;
	logic [63:0]        idle_time;
	logic               score_valid;
	logic               score_stall;
	logic signed [63:0] score;
	int                 fail_count;
	int                 pending;

	// stimulus-side bookkeeping: which edges exist, for values that sit on them
	bit              edge_written[TABLE_DEPTH];
	bfes_pkg::word_t edge_copy[TABLE_DEPTH];
	int unsigned     items_done;
	int unsigned     gap_odds;
	int unsigned     idle_cycles;
	bit              calm;
	bit              burst_on;
	bit              hold_req;

	always #1 clk = ~clk;

	binned_feature_eviction_scorer_top #(
		.FEATURE_COUNT(FEATURE_COUNT),
		.BIN_LIMIT(BIN_LIMIT)
	) dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.command(command), .table_addr(table_addr), .load_value(load_value),
		.page_delta(page_delta), .file_bytes(file_bytes), .page_hotness(page_hotness),
		.seq_distance(seq_distance), .page_delta_prev(page_delta_prev),
		.file_delta(file_delta), .file_delta_prev(file_delta_prev),
		.file_hotness(file_hotness), .idle_time(idle_time),
		.score_valid(score_valid), .score_stall(score_stall), .score(score)
	);

	bfes_score_checker #(
		.FEATURE_COUNT(FEATURE_COUNT),
		.BIN_LIMIT(BIN_LIMIT)
	) score_chk (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.command(command), .table_addr(table_addr), .load_value(load_value),
		.page_delta(page_delta), .file_bytes(file_bytes), .page_hotness(page_hotness),
		.seq_distance(seq_distance), .page_delta_prev(page_delta_prev),
		.file_delta(file_delta), .file_delta_prev(file_delta_prev),
		.file_hotness(file_hotness), .idle_time(idle_time),
		.score_valid(score_valid), .score_stall(score_stall), .score(score),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic bfes_pkg::word_t rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit narrow(int unsigned f);
		return f == 2 || f == 3 || f == 7;
	endfunction

	function automatic feat_vec_t random_features();
		feat_vec_t fv;
		for (int f = 0; f < bfes_pkg::INPUT_FEATURES; f++)
			fv[f] = rand64();
		return fv;
	endfunction

	// feature values cluster on the programmed edges to hit both sides of each
	function automatic bfes_pkg::word_t feature_value(int unsigned f);
		bfes_pkg::word_t v;
		int unsigned     idx;
		idx = f * BIN_LIMIT + $urandom_range(0, BIN_LIMIT - 2);
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2, 3, 4: v = edge_written[idx] ?
				edge_copy[idx] + 64'($urandom_range(0, 2)) - 64'd1 : rand64();
			5: v = rand64() >> $urandom_range(0, 63);
			default: v = rand64();
		endcase
		if (narrow(f))
			v[63:32] = '0;
		return v;
	endfunction

	function automatic bfes_pkg::word_t weight_value();
		case ($urandom_range(0, 7))
			0: return bfes_pkg::SCORE_MAX;
			1: return 64'h8000_0000_0000_0000;
			2: return '1;
			3: return '0;
			4, 5: return bfes_pkg::word_t'(longint'($urandom_range(0, 2000)) - 1000);
			default: return rand64();
		endcase
	endfunction

	task automatic issue(input code_t cmd, input addr_t addr,
			input bfes_pkg::word_t value, input feat_vec_t fv);
		@(negedge clk);
		if (!calm && !burst_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		command         <= cmd;
		table_addr      <= addr;
		load_value      <= value;
		page_delta      <= fv[0];
		file_bytes      <= fv[1];
		page_hotness    <= fv[2][31:0];
		seq_distance    <= fv[3][31:0];
		page_delta_prev <= fv[4];
		file_delta      <= fv[5];
		file_delta_prev <= fv[6];
		file_hotness    <= fv[7][31:0];
		idle_time       <= fv[8];
		valid           <= 1'b1;
		@(posedge clk);
		while (stall) @(posedge clk);
		if (cmd == bfes_pkg::CMD_LOAD_EDGE && addr < TABLE_DEPTH) begin
			edge_written[addr] = 1'b1;
			edge_copy[addr]    = value;
		end
		items_done++;
	endtask

	// write every edge and weight a count of n reads, then enable the feature
	task automatic program_feature(input int unsigned f, input int unsigned n);
		bfes_pkg::word_t cur;
		bfes_pkg::word_t step;
		bfes_pkg::word_t e;
		int unsigned     shift;
		shift = narrow(f) ? $urandom_range(8, 33) : $urandom_range(8, 63);
		step  = (64'd1 << shift) / 64'(n);
		if (step == 0)
			step = 64'd1;
		cur = '0;
		for (int unsigned b = 0; b + 1 < n; b++) begin
			cur = cur + 64'd1 + rand64() % step;
			e   = ($urandom_range(0, 7) == 0) ? rand64() : cur;
			issue(bfes_pkg::CMD_LOAD_EDGE, addr_t'(f * BIN_LIMIT + b), e, random_features());
		end
		for (int unsigned b = 0; b < n; b++)
			issue(bfes_pkg::CMD_LOAD_WEIGHT, addr_t'(f * BIN_LIMIT + b), weight_value(),
				random_features());
		issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(f), 64'(n), random_features());
	endtask

	task automatic random_command(input bit score_only);
		feat_vec_t   fv;
		int unsigned r;
		r  = score_only ? 0 : $urandom_range(0, 19);
		fv = random_features();
		if (r < 14) begin
			for (int unsigned f = 0; f < bfes_pkg::INPUT_FEATURES; f++)
				fv[f] = feature_value(f);
			issue(bfes_pkg::CMD_SCORE, addr_t'($urandom), rand64(), fv);
		end else begin
			case (r)
				14: issue(bfes_pkg::CMD_UNTRACKED, addr_t'($urandom), rand64(), fv);
				15: issue(bfes_pkg::CMD_NO_EVICT, addr_t'($urandom), rand64(), fv);
				16: issue($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI,
					addr_t'($urandom), rand64(), fv);
				17: issue(bfes_pkg::CMD_LOAD_EDGE, addr_t'($urandom_range(TABLE_DEPTH, 127)),
					rand64(), fv);
				18: issue(bfes_pkg::CMD_LOAD_WEIGHT,
					addr_t'($urandom_range(TABLE_DEPTH, 127)), rand64(), fv);
				default: issue(bfes_pkg::CMD_LOAD_COUNT,
					addr_t'($urandom_range(FEATURE_COUNT, 127)),
					64'($urandom_range(1, BIN_LIMIT)), fv);
			endcase
		end
	endtask

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		int unsigned stall_odds;
		bit          held;
		held        = 1'b0;
		stall_odds  = 3;
		score_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				stall_odds = $urandom_range(0, 3) * 3;
			if (hold_req && !held) begin
				held = 1'b1;
				score_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				score_stall <= 1'b0;
			end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				score_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				score_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (valid && !stall) || (score_valid && !score_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		feat_vec_t   fv;
		int unsigned f;
		int unsigned pick;
		arst_n          = 1'b1;
		valid           = 1'b0;
		command         = '0;
		table_addr      = '0;
		load_value      = '0;
		page_delta      = '0;
		file_bytes      = '0;
		page_hotness    = '0;
		seq_distance    = '0;
		page_delta_prev = '0;
		file_delta      = '0;
		file_delta_prev = '0;
		file_hotness    = '0;
		idle_time       = '0;
		items_done      = 0;
		gap_odds        = 3;
		calm            = 1'b0;
		burst_on        = 1'b0;
		hold_req        = 1'b0;
		// assert reset before the first rising edge, once every process waits on it
		#0.5 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: all features off, fixed codes, ignored codes and addresses
		fv = '1;
		issue(bfes_pkg::CMD_SCORE, '0, '0, fv);
		issue(bfes_pkg::CMD_UNTRACKED, '1, '1, fv);
		issue(bfes_pkg::CMD_NO_EVICT, '0, '0, '0);
		issue(CMD_SPARE_LO, '0, '0, fv);
		issue(CMD_SPARE_HI, '1, '1, fv);
		issue(bfes_pkg::CMD_LOAD_EDGE, '1, '1, fv);
		issue(bfes_pkg::CMD_LOAD_WEIGHT, addr_t'(TABLE_DEPTH), '1, fv);
		issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(FEATURE_COUNT), 64'd3, fv);
		// feature 0 with two bins, the low one weighted to the signed max
		issue(bfes_pkg::CMD_LOAD_EDGE, addr_t'(0), 64'd100, fv);
		issue(bfes_pkg::CMD_LOAD_WEIGHT, addr_t'(0), bfes_pkg::SCORE_MAX, fv);
		issue(bfes_pkg::CMD_LOAD_WEIGHT, addr_t'(1), 64'd5, fv);
		issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(0), 64'd2, fv);
		fv    = '0;
		fv[0] = 64'd99;
		issue(bfes_pkg::CMD_SCORE, '0, '0, fv);
		fv[0] = 64'd100;
		issue(bfes_pkg::CMD_SCORE, '1, '1, fv);
		issue(bfes_pkg::CMD_SCORE, '0, '0, '0);
		issue(bfes_pkg::CMD_SCORE, '0, '0, '1);
		// single-bin feature 8, weighted to the signed minimum, makes the sum negative
		issue(bfes_pkg::CMD_LOAD_WEIGHT, addr_t'(8 * BIN_LIMIT), 64'h8000_0000_0000_0000,
			'0);
		issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(8), 64'd1, '0);
		issue(bfes_pkg::CMD_SCORE, '0, '0, '1);
		issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(0), '1, '0);
		issue(bfes_pkg::CMD_SCORE, '0, '0, '1);
		issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(8), 64'(BIN_LIMIT + 1), '0);
		issue(bfes_pkg::CMD_SCORE, '0, '0, '1);

		while (items_done < ITEM_TARGET) begin
			if (items_done + CALM_TAIL >= ITEM_TARGET)
				calm = 1'b1;
			gap_odds = $urandom_range(0, 3) * 3;
			if (!hold_req && items_done >= HOLD_AT) begin
				hold_req = 1'b1;
				burst_on = 1'b1;
				repeat (24) random_command(1'b1);
				burst_on = 1'b0;
			end
			f    = $urandom_range(0, FEATURE_COUNT - 1);
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				program_feature(f, ($urandom_range(0, 3) == 0) ? BIN_LIMIT
					: $urandom_range(1, BIN_LIMIT));
			end else if (pick == 3) begin
				case ($urandom_range(0, 2))
					0: issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(f), '0, random_features());
					1: issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(f),
						64'($urandom_range(BIN_LIMIT + 1, 15)), random_features());
					default: issue(bfes_pkg::CMD_LOAD_COUNT, addr_t'(f),
						rand64() | (64'd1 << $urandom_range(4, 63)), random_features());
				endcase
			end else if (pick == 4) begin
				if ($urandom_range(0, 1))
					issue(bfes_pkg::CMD_LOAD_EDGE, addr_t'($urandom_range(0, TABLE_DEPTH - 1)),
						rand64(), random_features());
				else
					issue(bfes_pkg::CMD_LOAD_WEIGHT,
						addr_t'($urandom_range(0, TABLE_DEPTH - 1)), weight_value(),
						random_features());
			end
			repeat ($urandom_range(4, 24)) random_command(1'b0);
		end

		@(negedge clk);
		valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
